// ===== hdl/ilp_pkg.sv =====
`default_nettype none
package ilp_pkg;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_BAD_OCT   = 3'd2,
		ST_BAD_BIN   = 3'd3,
		ST_BAD_CHAR  = 3'd4,
		ST_OVERFLOW  = 3'd5,
		ST_NO_DIGITS = 3'd6
	} status_t;

	// character codes
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_8    = 8'h38;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] CH_UX   = 8'h58;
	localparam logic [7:0] CH_LO   = 8'h6f;
	localparam logic [7:0] CH_UO   = 8'h4f;
	localparam logic [7:0] CH_LB   = 8'h62;
	localparam logic [7:0] CH_UB   = 8'h42;

	localparam int ACC_W = 64;

	typedef struct packed {
		logic [7:0] ch;
		logic       no_char;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [ACC_W-1:0] value;
		status_t          status;
	} out_item_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		radix_t           radix;
		logic [1:0]       pos;
		logic             fwz;
		logic             seen;
		status_t          err;
	} parse_state_t;

	localparam parse_state_t STATE_CLEAR = '{
		acc:   '0,
		radix: RADIX_DEC,
		pos:   2'd0,
		fwz:   1'b0,
		seen:  1'b0,
		err:   ST_OK
	};

endpackage
`default_nettype wire

// ===== hdl/ilp_char_step.sv =====
`default_nettype none
module ilp_char_step (
	input  ilp_pkg::parse_state_t cur,
	input  ilp_pkg::in_item_t     item,
	output ilp_pkg::parse_state_t nxt,
	output ilp_pkg::out_item_t    res
);
	import ilp_pkg::*;

	always_comb begin
		logic [7:0]       c;
		logic [3:0]       digit;
		logic             dec_digit;
		logic             hex_letter;
		radix_t           sel;
		logic [ACC_W+3:0] wide;
		parse_state_t     tk;
		status_t          st;

		c          = item.ch;
		tk         = cur;
		digit      = 4'd0;
		dec_digit  = 1'b0;
		hex_letter = 1'b0;

		case (c) inside
			[CH_0:CH_9]: begin
				dec_digit = 1'b1;
				digit     = 4'(c - CH_0);
			end
			[CH_LA:CH_LF]: begin
				hex_letter = 1'b1;
				digit      = 4'(c - CH_LA + 8'd10);
			end
			[CH_UA:CH_UF]: begin
				hex_letter = 1'b1;
				digit      = 4'(c - CH_UA + 8'd10);
			end
			default: begin
				digit = 4'd0;
			end
		endcase

		case (c)
			CH_LX, CH_UX: sel = RADIX_HEX;
			CH_LO, CH_UO: sel = RADIX_OCT;
			CH_LB, CH_UB: sel = RADIX_BIN;
			default:      sel = RADIX_DEC;
		endcase

		// acc * radix by shifts, kept four bits wider for the overflow check
		case (cur.radix)
			RADIX_DEC: wide = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
			RADIX_HEX: wide = {cur.acc, 4'b0000};
			RADIX_OCT: wide = {1'b0, cur.acc, 3'b000};
			RADIX_BIN: wide = {3'b000, cur.acc, 1'b0};
			default:   wide = '0;
		endcase
		wide = wide + {{ACC_W{1'b0}}, digit};

		if (!item.no_char && cur.err == ST_OK) begin
			if (cur.pos != 2'd2)
				tk.pos = cur.pos + 2'd1;
			if (cur.radix == RADIX_DEC && cur.pos == 2'd1 && cur.fwz && sel != RADIX_DEC) begin
				// prefix letter: drop the leading zero and restart
				tk.radix = sel;
				tk.acc   = '0;
				tk.seen  = 1'b0;
				tk.pos   = 2'd0;
			end else begin
				if (cur.pos == 2'd0)
					tk.fwz = (c == CH_0);
				if (c != CH_APOS) begin
					if (cur.radix == RADIX_OCT && (c == CH_8 || c == CH_9))
						tk.err = ST_BAD_OCT;
					else if (cur.radix == RADIX_BIN && c != CH_0 && c != CH_1)
						tk.err = ST_BAD_BIN;
					else if (!dec_digit && !(cur.radix == RADIX_HEX && hex_letter))
						tk.err = ST_BAD_CHAR;
					else if (wide[ACC_W+3:ACC_W] != 4'd0)
						tk.err = ST_OVERFLOW;
					else begin
						tk.acc  = wide[ACC_W-1:0];
						tk.seen = 1'b1;
					end
				end
			end
		end

		if (tk.err != ST_OK)
			st = tk.err;
		else if (tk.pos == 2'd0)
			st = ST_EMPTY;
		else if (!tk.seen)
			st = ST_NO_DIGITS;
		else
			st = ST_OK;

		res.status = st;
		res.value  = (st == ST_OK) ? tk.acc : '0;
		nxt        = item.last ? STATE_CLEAR : tk;
	end

endmodule
`default_nettype wire

// ===== hdl/ilp_out_reg.sv =====
`default_nettype none
module ilp_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  ilp_pkg::out_item_t load_item,
	input  wire                res_ready,
	output logic               res_valid,
	output ilp_pkg::out_item_t res_item,
	output logic               free
);
	import ilp_pkg::*;

	assign free = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (free) begin
			res_valid <= load;
		end
	end

	// hold the result until transfer
	always_ff @(posedge clk) begin
		if (load && free)
			res_item <= load_item;
	end

endmodule
`default_nettype wire

// ===== hdl/integer_literal_parser.sv =====
`default_nettype none
// Integer literal parser.
// Character channel (char_valid/char_ready/char_item): one ASCII character per
// transfer, with no_char marking an item that only ends the string and last
// marking the final item of a literal. A leading 0x, 0o or 0b (either case)
// picks the radix, apostrophes are skipped, and the first error sticks.
// Result channel (res_valid/res_ready/res_item): one value and status for each
// transfer that had last set; value is zero whenever status is not ok.
// Order: a character is held in the input register and the parse state updates
// as it leaves; the result of a last item is then registered in the output
// register before it shows on the result channel. Throughput: one character
// per cycle unless a last item waits on a stalled result, set by the state
// update (shift-add of acc*radix+digit, overflow bits) feeding back on itself.
// Stall: while a result waits, further characters still transfer and parse; only
// a following last item waits in the input register, and char_ready drops then.
// Reset (arst_n low): both channels go empty and the parse state clears.
module integer_literal_parser (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               char_valid,
	output logic              char_ready,
	input  ilp_pkg::in_item_t  char_item,
	output logic              res_valid,
	input  wire               res_ready,
	output ilp_pkg::out_item_t res_item
);
	import ilp_pkg::*;

	logic         valid_s1;
	in_item_t     item_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	out_item_t    res_nxt;
	logic         out_free;
	logic         advance;

	// retire the staged item unless it carries a result with nowhere to go
	assign advance    = valid_s1 && (!item_s1.last || out_free);
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready)
			item_s1 <= char_item;
	end

	// parse state advances once per retired item, clears after a last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	ilp_char_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	ilp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && item_s1.last),
		.load_item (res_nxt),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_item  (res_item),
		.free      (out_free)
	);

endmodule
`default_nettype wire

// ===== hdl/ilp_checker.sv =====
`default_nettype none
module ilp_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                char_valid,
	input wire                char_ready,
	input ilp_pkg::in_item_t  char_item,
	input wire                res_valid,
	input wire                res_ready,
	input ilp_pkg::out_item_t res_item
);
	import ilp_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// the input side only backs up behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!char_ready |-> res_valid && !res_ready)
		else $error("char_ready low without a stalled result");

	// failed parses carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status != ST_OK |-> res_item.value == '0)
		else $error("nonzero value with error status");

	// a non-last character never yields a result straight after an idle output
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !(char_valid && char_ready && char_item.last) ##1 !res_valid
		|=> !res_valid)
		else $error("result without a last item");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);
`default_nettype wire
